// ----- hdl/atk_pkg.sv -----
// atk_pkg: shared types, widths, register codes and reset values for the aged top-k selector
// used by atk_ctrl, atk_datapath and aged_top_k_selector; depends on nothing
`timescale 1ns / 1ps

package atk_pkg;

    // field widths
    localparam int DIST_W   = 20;
    localparam int SKIP_W   = 6;
    localparam int WEIGHT_W = 12;
    localparam int AGE_W    = SKIP_W + WEIGHT_W;
    localparam int PRIO_W   = 21;

    // parameter defaults
    localparam int QUEUE_DEPTH_DEF = 24;
    localparam int ID_BITS_DEF     = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_AGING_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CAP     = 2'd1;

    localparam logic [WEIGHT_W-1:0] AGING_WEIGHT_RST = 12'd256;
    localparam logic [SKIP_W-1:0]   SKIP_CAP_RST     = 6'd32;

    // result kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_EMIT
    } t_atk_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic insert;
        logic emit;
    } t_atk_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic more;
        logic emit_last;
        logic empty;
    } t_atk_stat;

endpackage

// ----- hdl/aged_top_k_selector.sv -----
// Aged top-k selector. Each request offers one candidate; a dirty one is aged
// (distance minus skipped times aging_weight) and placed into a sorted buffer of
// QUEUE_DEPTH entries, after entries of equal priority, the worst entry falling out
// when full. Every request yields one skip-count update; a frame_end request then
// also yields the buffer best first and empties it. A request is first accepted,
// forming the aged priority through the 6x12 multiplier, and is then inserted by the
// parallel compare-and-shift across all buffer entries, which also loads the
// update into the result register. Frame end then pops the buffered entries from
// the head; no request is accepted until idle again. Every result waits in the
// single result register while i_out_stall is high, holding the sequencer.
// Configuration writes are always ready and must only be made while idle.
// depends on atk_pkg, atk_ctrl, atk_datapath
`timescale 1ns / 1ps

module aged_top_k_selector #(
    parameter int QUEUE_DEPTH = atk_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = atk_pkg::ID_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [atk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [atk_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // candidate channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ID_BITS-1:0]                 i_cand_id,
    input  logic [atk_pkg::DIST_W-1:0]         i_distance,
    input  logic                               i_dirty,
    input  logic [atk_pkg::SKIP_W-1:0]         i_skipped,
    input  logic                               i_frame_end,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_kind,
    output logic [ID_BITS-1:0]                 o_out_id,
    output logic signed [atk_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [atk_pkg::SKIP_W-1:0]         o_new_skipped,
    output logic                               o_final_res
);

    atk_pkg::t_atk_cmd  w_cmd;
    atk_pkg::t_atk_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    atk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // datapath
    atk_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cand_id      (i_cand_id),
        .i_distance     (i_distance),
        .i_dirty        (i_dirty),
        .i_skipped      (i_skipped),
        .i_frame_end    (i_frame_end),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_new_skipped  (o_new_skipped),
        .o_final_res    (o_final_res),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat)
    );

`ifndef NO_ASSERTIONS
    // only one datapath command at a time
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.capture, w_cmd.insert, w_cmd.emit}))
        else $error("more than one datapath command");

    // an accepted request is followed by its insertion, never by another request
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one in progress");

    // emission never pops an empty buffer
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !w_stat.empty)
        else $error("emit from empty buffer");

    // the last emitted entry leaves the buffer empty
    a_emit_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_stat.emit_last) |=> w_stat.empty)
        else $error("buffer not empty after last entry");
`endif

endmodule

// ----- hdl/atk_ctrl.sv -----
// atk_ctrl: sequencer for accept, insertion and frame-end emission
// depends on atk_pkg
`timescale 1ns / 1ps

module atk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output atk_pkg::t_atk_cmd o_cmd,
    input  atk_pkg::t_atk_stat i_stat
);

    atk_pkg::t_atk_state r_state;
    atk_pkg::t_atk_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            atk_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = atk_pkg::ST_INS;
                end
            end
            atk_pkg::ST_INS: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.more ? atk_pkg::ST_EMIT : atk_pkg::ST_IDLE;
                end
            end
            atk_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = atk_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atk_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            atk_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            atk_pkg::ST_INS: begin
                o_cmd.insert = i_stat.out_free;
            end
            atk_pkg::ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/atk_datapath.sv -----
// atk_datapath: config registers, aging, sorted compare-and-shift buffer, result register
// depends on atk_pkg; driven by atk_ctrl commands
`timescale 1ns / 1ps

module atk_datapath #(
    parameter int QUEUE_DEPTH = atk_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = atk_pkg::ID_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [atk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [atk_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // request fields
    input  logic [ID_BITS-1:0]                  i_cand_id,
    input  logic [atk_pkg::DIST_W-1:0]          i_distance,
    input  logic                                i_dirty,
    input  logic [atk_pkg::SKIP_W-1:0]          i_skipped,
    input  logic                                i_frame_end,
    // result register
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_kind,
    output logic [ID_BITS-1:0]                  o_out_id,
    output logic signed [atk_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [atk_pkg::SKIP_W-1:0]          o_new_skipped,
    output logic                                o_final_res,
    // control
    input  atk_pkg::t_atk_cmd                   i_cmd,
    output atk_pkg::t_atk_stat                  o_stat
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = atk_pkg::PRIO_W;
    localparam int SW    = atk_pkg::SKIP_W;

    // configuration registers
    logic [atk_pkg::WEIGHT_W-1:0] r_aging_weight;
    logic [SW-1:0]                r_skip_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging_weight <= atk_pkg::AGING_WEIGHT_RST;
            r_skip_cap     <= atk_pkg::SKIP_CAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                atk_pkg::CFG_AGING_WEIGHT: r_aging_weight <= i_cfg_data[atk_pkg::WEIGHT_W-1:0];
                atk_pkg::CFG_SKIP_CAP:     r_skip_cap     <= i_cfg_data[SW-1:0];
                default:                   ;
            endcase
        end
    end

    // aged priority and new skip count, computed at accept
    logic [atk_pkg::AGE_W-1:0] w_age;
    logic signed [PW-1:0]      w_aged;
    logic [SW:0]               w_inc;
    logic [SW-1:0]             w_new_skip;

    assign w_age  = atk_pkg::AGE_W'(i_skipped) * atk_pkg::AGE_W'(r_aging_weight);
    assign w_aged = $signed({1'b0, i_distance})
                  - $signed({{(PW - atk_pkg::AGE_W){1'b0}}, w_age});
    assign w_inc  = {1'b0, i_skipped} + {{SW{1'b0}}, 1'b1};

    always_comb begin
        w_new_skip = i_skipped;
        if (i_dirty) begin
            w_new_skip = (w_inc > {1'b0, r_skip_cap}) ? r_skip_cap : w_inc[SW-1:0];
        end
    end

    // captured request
    logic [ID_BITS-1:0]   r_id;
    logic signed [PW-1:0] r_prio;
    logic                 r_dirty;
    logic                 r_fend;
    logic [SW-1:0]        r_new_skip;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id       <= i_cand_id;
            r_prio     <= w_aged;
            r_dirty    <= i_dirty;
            r_fend     <= i_frame_end;
            r_new_skip <= w_new_skip;
        end
    end

    // sorted buffer, best entry at index 0
    logic [ID_BITS-1:0]   r_ent_id   [QUEUE_DEPTH];
    logic signed [PW-1:0] r_ent_prio [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   n_ent_id   [QUEUE_DEPTH];
    logic signed [PW-1:0] n_ent_prio [QUEUE_DEPTH];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic [QUEUE_DEPTH-1:0] w_gt;
    logic [QUEUE_DEPTH-1:0] w_up_gt;
    logic [ID_BITS-1:0]     w_up_id   [QUEUE_DEPTH];
    logic signed [PW-1:0]   w_up_prio [QUEUE_DEPTH];
    logic [ID_BITS-1:0]     w_dn_id   [QUEUE_DEPTH];
    logic signed [PW-1:0]   w_dn_prio [QUEUE_DEPTH];

    // per-entry compare and neighbor taps; free slots count as worse
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_ent
        assign w_gt[gi] = (CNT_W'(gi) >= r_count) || (r_ent_prio[gi] > r_prio);
        if (gi == 0) begin : g_first
            assign w_up_gt[gi]   = 1'b0;
            assign w_up_id[gi]   = r_ent_id[gi];
            assign w_up_prio[gi] = r_ent_prio[gi];
        end else begin : g_rest
            assign w_up_gt[gi]   = w_gt[gi-1];
            assign w_up_id[gi]   = r_ent_id[gi-1];
            assign w_up_prio[gi] = r_ent_prio[gi-1];
        end
        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_dn_id[gi]   = r_ent_id[gi];
            assign w_dn_prio[gi] = r_ent_prio[gi];
        end else begin : g_body
            assign w_dn_id[gi]   = r_ent_id[gi+1];
            assign w_dn_prio[gi] = r_ent_prio[gi+1];
        end
    end

    // next buffer contents: pop the head, or insert after equal entries
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_ent_id[i]   = r_ent_id[i];
            n_ent_prio[i] = r_ent_prio[i];
            if (i_cmd.emit) begin
                n_ent_id[i]   = w_dn_id[i];
                n_ent_prio[i] = w_dn_prio[i];
            end else if (i_cmd.insert && r_dirty && w_gt[i]) begin
                if (w_up_gt[i]) begin
                    n_ent_id[i]   = w_up_id[i];
                    n_ent_prio[i] = w_up_prio[i];
                end else begin
                    n_ent_id[i]   = r_id;
                    n_ent_prio[i] = r_prio;
                end
            end
        end
    end

    // occupancy after this request's insertion
    logic [CNT_W-1:0] w_count_ins;
    assign w_count_ins = (r_dirty && (r_count != CNT_W'(QUEUE_DEPTH)))
                       ? r_count + CNT_W'(1) : r_count;

    always_comb begin
        n_count = r_count;
        if (i_cmd.emit) begin
            n_count = r_count - CNT_W'(1);
        end else if (i_cmd.insert) begin
            n_count = w_count_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent_id   <= n_ent_id;
        r_ent_prio <= n_ent_prio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [ID_BITS-1:0]   r_out_id;
    logic signed [PW-1:0] r_out_prio;
    logic [SW-1:0]        r_out_skip;
    logic                 r_out_final;
    logic                 w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.insert || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_out_kind  <= atk_pkg::KIND_UPDATE;
            r_out_id    <= r_id;
            r_out_prio  <= '0;
            r_out_skip  <= r_new_skip;
            r_out_final <= !r_fend || (w_count_ins == '0);
        end else if (i_cmd.emit) begin
            r_out_kind  <= atk_pkg::KIND_ENTRY;
            r_out_id    <= r_ent_id[0];
            r_out_prio  <= r_ent_prio[0];
            r_out_skip  <= '0;
            r_out_final <= (r_count == CNT_W'(1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_new_skipped  = r_out_skip;
    assign o_final_res    = r_out_final;

    // status
    assign o_stat.out_free  = w_out_free;
    assign o_stat.more      = r_fend && (w_count_ins != '0);
    assign o_stat.emit_last = (r_count == CNT_W'(1));
    assign o_stat.empty     = (r_count == '0);

endmodule

// ----- bench/aged_top_k_selector_test.sv -----
// aged_top_k_selector_test: self-checking bench for the aged top-k selector, holding its own
// model of the sorted candidate buffer, with random request gaps and result stalls
// depends on atk_pkg and aged_top_k_selector
`timescale 1ns / 1ps

module aged_top_k_selector_test;

    import atk_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int ID_W        = ID_BITS_DEF;
    localparam int HOLD_OFF    = 4;
    localparam int END_WAIT    = 8;
    localparam int PHASES      = 5;
    localparam int PHASE_DIRTY = 48;

    typedef enum logic {
        STEP_CAND,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              dirty;
        logic [SKIP_W-1:0] skipped;
        logic              frame_end;
    } t_cand;

    typedef struct {
        t_step_kind            kind;
        t_cand                 cand;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_step;

    typedef struct {
        logic                     kind;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [SKIP_W-1:0]        new_skipped;
        logic                     final_res;
    } t_result;

    // clock, reset and driven inputs
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_cand                 drv_cand  = '0;
    logic                  out_stall = 1'b0;

    // block outputs
    logic                     cfg_ready;
    logic                     in_stall;
    logic                     out_valid;
    logic                     res_kind;
    logic [ID_W-1:0]          res_id;
    logic signed [PRIO_W-1:0] res_prio;
    logic [SKIP_W-1:0]        res_new_skipped;
    logic                     res_final;

    // handshake flags seen at the last rising edge
    logic in_took  = 1'b0;
    logic cfg_took = 1'b0;

    // own copy of the selector state
    logic [WEIGHT_W-1:0]      aging_weight = AGING_WEIGHT_RST;
    logic [SKIP_W-1:0]        skip_cap     = SKIP_CAP_RST;
    logic [ID_W-1:0]          held_id   [DEPTH];
    logic signed [PRIO_W-1:0] held_prio [DEPTH];
    int                       held_count = 0;

    t_result due_results[$];
    t_step   request_plan[$];

    // idling control
    int gap_left   = 0;
    int stall_left = 0;
    int calm_left  = 0;
    int quiet      = 0;

    // run statistics
    int mismatches    = 0;
    int items_taken   = 0;
    int dirty_taken   = 0;
    int frames_closed = 0;
    int writes_taken  = 0;
    int results_seen  = 0;
    int entries_seen  = 0;

    aged_top_k_selector dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cand_id      (drv_cand.id),
        .i_distance     (drv_cand.distance),
        .i_dirty        (drv_cand.dirty),
        .i_skipped      (drv_cand.skipped),
        .i_frame_end    (drv_cand.frame_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (res_kind),
        .o_out_id       (res_id),
        .o_out_priority (res_prio),
        .o_new_skipped  (res_new_skipped),
        .o_final_res    (res_final)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short pauses, now and then a long one
    function automatic int draw_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // age a candidate, place it in the sorted buffer, queue the results it causes
    task automatic rank_candidate(input t_cand c);
        logic signed [PRIO_W-1:0] aged;
        int slot;
        int last;
        int bumped;
        t_result r;
        slot   = held_count;
        bumped = int'(c.skipped);
        if (c.dirty) begin
            aged = PRIO_W'(int'(c.distance) - int'(c.skipped) * int'(aging_weight));
            // first entry strictly worse; equal ones stay ahead
            for (int i = held_count - 1; i >= 0; i--)
                if (held_prio[i] > aged) slot = i;
            if (slot < DEPTH) begin
                last = (held_count < DEPTH) ? held_count : DEPTH - 1;
                for (int i = last; i > slot; i--) begin
                    held_id[i]   = held_id[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_id[slot]   = c.id;
                held_prio[slot] = aged;
                if (held_count < DEPTH) held_count++;
            end
            bumped = int'(c.skipped) + 1;
            if (bumped > int'(skip_cap)) bumped = int'(skip_cap);
        end
        r.kind        = KIND_UPDATE;
        r.id          = c.id;
        r.prio        = '0;
        r.new_skipped = SKIP_W'(bumped);
        r.final_res   = !c.frame_end || held_count == 0;
        due_results.push_back(r);
        // frame end: whole buffer, best first, then empty
        if (c.frame_end) begin
            for (int i = 0; i < held_count; i++) begin
                r.kind        = KIND_ENTRY;
                r.id          = held_id[i];
                r.prio        = held_prio[i];
                r.new_skipped = '0;
                r.final_res   = (i == held_count - 1);
                due_results.push_back(r);
            end
            held_count = 0;
        end
    endtask

    task automatic plan_cand(input logic [ID_W-1:0] id, input logic [DIST_W-1:0] distance,
                             input logic dirty, input logic [SKIP_W-1:0] skipped,
                             input logic fend);
        t_step s;
        s.kind               = STEP_CAND;
        s.cand.id            = id;
        s.cand.distance      = distance;
        s.cand.dirty         = dirty;
        s.cand.skipped       = skipped;
        s.cand.frame_end     = fend;
        s.index              = '0;
        s.data               = '0;
        request_plan.push_back(s);
    endtask

    task automatic plan_write(input logic [CFG_IDX_W-1:0] index, input int value);
        t_step s;
        s.kind  = STEP_CFG;
        s.cand  = '0;
        s.index = index;
        s.data  = CFG_DATA_W'(value);
        request_plan.push_back(s);
    endtask

    // monitor: check results, track register writes, predict accepted requests
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            in_took  <= 1'b0;
            cfg_took <= 1'b0;
        end else begin
            in_took  <= in_valid && !in_stall;
            cfg_took <= cfg_valid && cfg_ready;

            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result with nothing due, id", -1, res_id);
                end else begin
                    want = due_results.pop_front();
                    results_seen++;
                    if (want.kind == KIND_ENTRY) entries_seen++;
                    if (res_kind != want.kind)
                        flag_mismatch("kind", want.kind, res_kind);
                    if (res_id != want.id)
                        flag_mismatch("out_id", want.id, res_id);
                    if (res_prio != want.prio)
                        flag_mismatch("out_priority", want.prio, res_prio);
                    if (res_new_skipped != want.new_skipped)
                        flag_mismatch("new_skipped", want.new_skipped, res_new_skipped);
                    if (res_final != want.final_res)
                        flag_mismatch("final_res", want.final_res, res_final);
                end
            end

            if (cfg_valid && cfg_ready) begin
                writes_taken++;
                if (cfg_index == CFG_AGING_WEIGHT)
                    aging_weight = cfg_data[WEIGHT_W-1:0];
                else if (cfg_index == CFG_SKIP_CAP)
                    skip_cap = cfg_data[SKIP_W-1:0];
            end

            if (in_valid && !in_stall) begin
                items_taken++;
                if (drv_cand.dirty) dirty_taken++;
                if (drv_cand.frame_end) frames_closed++;
                rank_candidate(drv_cand);
            end
        end
    end

    // driver: requests, register writes and result stalls, all on the falling edge
    always @(negedge clk) begin
        t_step s;
        logic  launch;
        logic  stall_now;
        launch = 1'b0;
        if (rst_n) begin
            // calm stretches with no idling on either side
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 200);

            // candidate requests
            if (in_valid && in_took) gap_left = (calm_left > 0) ? 0 : draw_pause();
            if (!in_valid || in_took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (request_plan.size() > 0 && request_plan[0].kind == STEP_CAND
                             && !cfg_valid) begin
                    s = request_plan.pop_front();
                    drv_cand <= s.cand;
                    in_valid <= 1'b1;
                    launch   = 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end

            // register writes, only once the block has gone quiet
            if (!in_valid && due_results.size() == 0) quiet++;
            else quiet = 0;
            if (cfg_valid) begin
                if (cfg_took) cfg_valid <= 1'b0;
            end else if (!launch && !in_valid && quiet >= HOLD_OFF && request_plan.size() > 0
                         && request_plan[0].kind == STEP_CFG) begin
                s = request_plan.pop_front();
                cfg_index <= s.index;
                cfg_data  <= s.data;
                cfg_valid <= 1'b1;
            end

            // result stalls
            if (stall_left == 0 && calm_left == 0 && $urandom_range(0, 2) == 0)
                stall_left = draw_pause();
            stall_now = stall_left > 0;
            if (stall_left > 0) stall_left--;
            out_stall <= stall_now;
        end
    end

    // stimulus plan, reset, drain and verdict
    initial begin
        int                budget;
        int                length;
        int                roll;
        logic [DIST_W-1:0] dist_draw;
        logic [SKIP_W-1:0] skip;
        logic              dirty;

        // reset weights: clean frame end on an empty buffer, then aging and cap cases
        plan_cand(16'hFFFF, 20'hFFFFF, 1'b0, 6'd63, 1'b1);
        plan_cand(16'h0000, 20'h00000, 1'b1, 6'd0,  1'b0);
        plan_cand(16'h8001, 20'hFFFFF, 1'b1, 6'd0,  1'b0);
        plan_cand(16'h1234, 20'h00000, 1'b1, 6'd63, 1'b0);
        plan_cand(16'h4321, 20'd100,   1'b1, 6'd31, 1'b0);
        plan_cand(16'h00AA, 20'h00000, 1'b1, 6'd0,  1'b0);
        plan_cand(16'h5555, 20'h55555, 1'b0, 6'd21, 1'b0);
        plan_cand(16'hAAAA, 20'hAAAAA, 1'b1, 6'd42, 1'b1);
        plan_cand(16'h0007, 20'd50,    1'b0, 6'd5,  1'b1);
        // heaviest aging, widest cap
        plan_write(CFG_AGING_WEIGHT, 4095);
        plan_write(CFG_SKIP_CAP, 63);
        plan_cand(16'h0F0F, 20'h00000, 1'b1, 6'd63, 1'b0);
        plan_cand(16'hF0F0, 20'hFFFFF, 1'b1, 6'd62, 1'b0);
        plan_cand(16'h0003, 20'd4095,  1'b1, 6'd1,  1'b1);
        // no aging, cap of zero
        plan_write(CFG_AGING_WEIGHT, 0);
        plan_write(CFG_SKIP_CAP, 0);
        plan_cand(16'h0009, 20'd77,    1'b1, 6'd10, 1'b0);
        plan_cand(16'h000A, 20'd77,    1'b1, 6'd0,  1'b0);
        plan_cand(16'h000B, 20'd76,    1'b0, 6'd33, 1'b1);

        // random frames under several register settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    plan_write(CFG_AGING_WEIGHT, 4095);
                    plan_write(CFG_SKIP_CAP, 63);
                end
                1: begin
                    plan_write(CFG_AGING_WEIGHT, 0);
                    plan_write(CFG_SKIP_CAP, 0);
                end
                2: begin
                    plan_write(CFG_AGING_WEIGHT, 1);
                    plan_write(CFG_SKIP_CAP, 1);
                end
                3: begin
                    plan_write(CFG_AGING_WEIGHT, $urandom_range(2, 4094));
                    plan_write(CFG_SKIP_CAP, $urandom_range(2, 62));
                end
                default: begin
                    plan_write(CFG_AGING_WEIGHT, AGING_WEIGHT_RST);
                    plan_write(CFG_SKIP_CAP, SKIP_CAP_RST);
                end
            endcase
            budget = 0;
            for (int f = 0; budget < PHASE_DIRTY; f++) begin
                // first frame of a phase is longer than the buffer, later ones mostly short
                if (f == 0) length = 30;
                else if ($urandom_range(0, 6) == 0) length = $urandom_range(25, 40);
                else length = $urandom_range(1, 10);
                for (int n = 0; n < length; n++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 40) dist_draw = DIST_W'($urandom);
                    else if (roll < 65) dist_draw = DIST_W'($urandom_range(0, 15));
                    else if (roll < 75) dist_draw = roll[0] ? '1 : '0;
                    else dist_draw = DIST_W'($urandom_range(0, 4095));
                    roll = $urandom_range(0, 99);
                    if (roll < 70) skip = SKIP_W'($urandom_range(0, 63));
                    else if (roll < 85) skip = roll[0] ? '1 : '0;
                    else skip = SKIP_W'($urandom_range(0, 3));
                    dirty = $urandom_range(0, 3) != 0;
                    if (dirty) budget++;
                    plan_cand(ID_W'($urandom), dist_draw, dirty, skip, n == length - 1);
                end
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_plan.size() > 0 || in_valid || cfg_valid || due_results.size() > 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        $display("ran %0d candidates (%0d dirty) over %0d frames with %0d register writes",
                 items_taken, dirty_taken, frames_closed, writes_taken);
        $display("checked %0d results, %0d of them buffered entries", results_seen,
                 entries_seen);
        if (mismatches == 0)
            $display("aged_top_k_selector: match");
        else
            $display("aged_top_k_selector: mismatch");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #15_000_000;
        $display("aged_top_k_selector: mismatch");
        $finish;
    end

endmodule

// ----- aged_top_k_selector.f -----
hdl/atk_pkg.sv
hdl/atk_ctrl.sv
hdl/atk_datapath.sv
hdl/aged_top_k_selector.sv
bench/aged_top_k_selector_test.sv
